/* design/dsdas_pkg.sv */
// Shared types and constants for the dual sensor decimate, average and scale block.
// Holds the field widths, the reset values of the settings registers and the register
// index codes. Used by dual_sensor_decimate_average_scale.
package dsdas_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;   // raw converter reading
  localparam int GSUM_W   = 15;   // group sum
  localparam int AVG_W    = 12;   // block average
  localparam int WSUM_W   = 16;   // window sum over the history
  localparam int GAIN_W   = 16;
  localparam int OFFS_W   = 16;
  localparam int EC_W     = 11;   // conductivity result, hundredths
  localparam int TEMP_W   = 14;   // temperature result, hundredths
  localparam int THR_W    = 10;
  localparam int LEC_W    = 12;   // last conductivity shown, signed

  // Settings port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EC_GAIN        = 3'd0,
    CFG_TEMP_GAIN      = 3'd1,
    CFG_TEMP_OFFSET    = 3'd2,
    CFG_EC_MAX         = 3'd3,
    CFG_TEMP_MIN       = 3'd4,
    CFG_TEMP_MAX       = 3'd5,
    CFG_EC_THRESHOLD   = 3'd6,
    CFG_TEMP_THRESHOLD = 3'd7
  } cfg_idx_t;

  // Reset values of the settings registers
  localparam logic [GAIN_W-1:0]        EC_GAIN_RST        = 16'd3670;
  localparam logic [GAIN_W-1:0]        TEMP_GAIN_RST      = 16'd26214;
  localparam logic signed [OFFS_W-1:0] TEMP_OFFSET_RST    = -16'sd1300;
  localparam logic [EC_W-1:0]          EC_MAX_RST         = 11'd700;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN_RST       = -14'sd1000;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX_RST       = 14'sd5000;
  localparam logic [THR_W-1:0]         EC_THRESHOLD_RST   = 10'd10;
  localparam logic [THR_W-1:0]         TEMP_THRESHOLD_RST = 10'd1;

  // Last values shown start at -1.00
  localparam logic signed [LEC_W-1:0]  LAST_EC_RST   = -12'sd100;
  localparam logic signed [TEMP_W-1:0] LAST_TEMP_RST = -14'sd100;

  // Reciprocal divide by the group size: exact for every 15-bit sum and group sizes up to 8
  localparam int DIV_SH = 18;

endpackage

/* design/dual_sensor_decimate_average_scale.sv */
// Top level of the dual sensor decimate, average and scale block: group sums, history,
// window sums, Q16 scaling, clamps and change flags in one pipeline.
// Depends on dsdas_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   in_     | input     | in_tvalid/in_tready   | tdata: ec_sample, temp_sample; tuser: restart
//   out_    | output    | out_tvalid/out_tready | tdata: ec_centi, temp_centi; tuser: flags
//   cfg_    | input     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One sample pair is taken every cycle while in_tready is high; a result passes through
// the five register stages (group sum, divide, history, multiply, clamp) and then the
// output register after the beat that completes its group.
// Reset clears all control state, histories, window sums and last values shown at once.
// All stages advance together; when a result waits at the output, the pipeline and
// in_tready hold until out_tready takes it. cfg_ready is always high.
module dual_sensor_decimate_average_scale #(
  parameter int GROUP_SIZE    = 5,
  parameter int HISTORY_DEPTH = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Sample pairs
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [2*dsdas_pkg::SAMPLE_W-1:0]    in_tdata,   // [11:0] ec_sample, [23:12] temp_sample
  input  logic                                in_tuser,   // [0] restart
  // Results
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,  // [10:0] ec_centi, [24:11] temp_centi, zero pad
  output logic [1:0]                          out_tuser,  // [0] ec_changed, [1] temp_changed
  // Settings writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dsdas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dsdas_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dsdas_pkg::*;

  localparam int CNT_W  = $clog2(GROUP_SIZE + 1);
  localparam int RCP_W  = DIV_SH + 1;
  localparam int PROD_W = GSUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((1 << DIV_SH) + GROUP_SIZE - 1) / GROUP_SIZE);
  localparam logic [CNT_W-1:0] GROUP_LAST = CNT_W'(GROUP_SIZE);

  // ---------------------------------------------------------------------------
  // Settings registers
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]        ec_gain_r, temp_gain_r;
  logic signed [OFFS_W-1:0] temp_offset_r;
  logic [EC_W-1:0]          ec_max_r;
  logic signed [TEMP_W-1:0] temp_min_r, temp_max_r;
  logic [THR_W-1:0]         ec_thr_r, temp_thr_r;

  assign cfg_ready = 1'b1;

  // Write one register per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_gain_r     <= EC_GAIN_RST;
      temp_gain_r   <= TEMP_GAIN_RST;
      temp_offset_r <= TEMP_OFFSET_RST;
      ec_max_r      <= EC_MAX_RST;
      temp_min_r    <= TEMP_MIN_RST;
      temp_max_r    <= TEMP_MAX_RST;
      ec_thr_r      <= EC_THRESHOLD_RST;
      temp_thr_r    <= TEMP_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_EC_GAIN:        ec_gain_r     <= cfg_data;
        CFG_TEMP_GAIN:      temp_gain_r   <= cfg_data;
        CFG_TEMP_OFFSET:    temp_offset_r <= cfg_data;
        CFG_EC_MAX:         ec_max_r      <= cfg_data[EC_W-1:0];
        CFG_TEMP_MIN:       temp_min_r    <= cfg_data[TEMP_W-1:0];
        CFG_TEMP_MAX:       temp_max_r    <= cfg_data[TEMP_W-1:0];
        CFG_EC_THRESHOLD:   ec_thr_r      <= cfg_data[THR_W-1:0];
        CFG_TEMP_THRESHOLD: temp_thr_r    <= cfg_data[THR_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: every stage moves when the output register is free
  // ---------------------------------------------------------------------------
  logic adv;
  logic in_acc;
  logic out_vld_r;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  // ---------------------------------------------------------------------------
  // Stage 1: group accumulation
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] ec_s, tp_s;
  logic [CNT_W-1:0]    cnt_r, cnt_base, cnt_inc;
  logic [GSUM_W-1:0]   ec_gsum_r, tp_gsum_r, ec_gsum_nxt, tp_gsum_nxt;
  logic                clr_pend_r;
  logic                grp_done;
  logic                s1_vld_r, s1_clr_r;
  logic [GSUM_W-1:0]   s1_ec_sum_r, s1_tp_sum_r;

  assign ec_s = in_tdata[SAMPLE_W-1:0];
  assign tp_s = in_tdata[2*SAMPLE_W-1:SAMPLE_W];

  // Restart starts the group afresh before this beat is added
  always_comb begin
    cnt_base    = in_tuser ? '0 : cnt_r;
    cnt_inc     = cnt_base + 1'b1;
    ec_gsum_nxt = (in_tuser ? '0 : ec_gsum_r) + GSUM_W'(ec_s);
    tp_gsum_nxt = (in_tuser ? '0 : tp_gsum_r) + GSUM_W'(tp_s);
    grp_done    = (cnt_inc == GROUP_LAST);
  end

  // Hold the group state; a pending restart rides with the next finished group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      ec_gsum_r  <= '0;
      tp_gsum_r  <= '0;
      clr_pend_r <= 1'b0;
    end else if (in_acc) begin
      if (grp_done) begin
        cnt_r      <= '0;
        ec_gsum_r  <= '0;
        tp_gsum_r  <= '0;
        clr_pend_r <= 1'b0;
      end else begin
        cnt_r      <= cnt_inc;
        ec_gsum_r  <= ec_gsum_nxt;
        tp_gsum_r  <= tp_gsum_nxt;
        clr_pend_r <= clr_pend_r | in_tuser;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_acc && grp_done;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ec_sum_r <= ec_gsum_nxt;
      s1_tp_sum_r <= tp_gsum_nxt;
      s1_clr_r    <= clr_pend_r | in_tuser;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: block average, divide by the group size through a reciprocal
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] ec_quo, tp_quo;
  logic              s2_vld_r, s2_clr_r;
  logic [AVG_W-1:0]  s2_ec_avg_r, s2_tp_avg_r;

  assign ec_quo = PROD_W'(s1_ec_sum_r) * PROD_W'(RECIP);
  assign tp_quo = PROD_W'(s1_tp_sum_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ec_avg_r <= ec_quo[DIV_SH +: AVG_W];
      s2_tp_avg_r <= tp_quo[DIV_SH +: AVG_W];
      s2_clr_r    <= s1_clr_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: history shift line and running window sums
  // ---------------------------------------------------------------------------
  logic [AVG_W-1:0]  ec_hist_r [HISTORY_DEPTH];
  logic [AVG_W-1:0]  tp_hist_r [HISTORY_DEPTH];
  logic [AVG_W-1:0]  ec_oldest, tp_oldest;
  logic [WSUM_W-1:0] ec_wsum_r, tp_wsum_r, ec_wsum_nxt, tp_wsum_nxt;
  logic              s3_vld_r, s3_clr_r;

  // Drop the oldest average, add the new one; a restart empties the window first
  always_comb begin
    ec_oldest   = s2_clr_r ? '0 : ec_hist_r[0];
    tp_oldest   = s2_clr_r ? '0 : tp_hist_r[0];
    ec_wsum_nxt = (s2_clr_r ? '0 : ec_wsum_r) - WSUM_W'(ec_oldest) + WSUM_W'(s2_ec_avg_r);
    tp_wsum_nxt = (s2_clr_r ? '0 : tp_wsum_r) - WSUM_W'(tp_oldest) + WSUM_W'(s2_tp_avg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        ec_hist_r[i] <= '0;
        tp_hist_r[i] <= '0;
      end
      ec_wsum_r <= '0;
      tp_wsum_r <= '0;
    end else if (adv && s2_vld_r) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        ec_hist_r[i] <= s2_clr_r ? '0 : ec_hist_r[i+1];
        tp_hist_r[i] <= s2_clr_r ? '0 : tp_hist_r[i+1];
      end
      ec_hist_r[HISTORY_DEPTH-1] <= s2_ec_avg_r;
      tp_hist_r[HISTORY_DEPTH-1] <= s2_tp_avg_r;
      ec_wsum_r <= ec_wsum_nxt;
      tp_wsum_r <= tp_wsum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_clr_r <= s2_clr_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: Q16 scaling, one multiply per channel
  // ---------------------------------------------------------------------------
  logic [2*WSUM_W-1:0] ec_prod, tp_prod;
  logic                s4_vld_r, s4_clr_r;
  logic [WSUM_W-1:0]   s4_ec_sc_r, s4_tp_sc_r;

  assign ec_prod = (2*WSUM_W)'(ec_wsum_r) * (2*WSUM_W)'(ec_gain_r);
  assign tp_prod = (2*WSUM_W)'(tp_wsum_r) * (2*WSUM_W)'(temp_gain_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ec_sc_r <= ec_prod[2*WSUM_W-1:WSUM_W];
      s4_tp_sc_r <= tp_prod[2*WSUM_W-1:WSUM_W];
      s4_clr_r   <= s3_clr_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: temperature offset and clamps
  // ---------------------------------------------------------------------------
  logic [EC_W-1:0]          ec_clamp;
  logic signed [17:0]       tp_sum, tp_min18, tp_max18;
  logic signed [TEMP_W-1:0] tp_clamp;
  logic                     s5_vld_r, s5_clr_r;
  logic [EC_W-1:0]          s5_ec_r;
  logic signed [TEMP_W-1:0] s5_tp_r;

  always_comb begin
    ec_clamp = (s4_ec_sc_r > WSUM_W'(ec_max_r)) ? ec_max_r : s4_ec_sc_r[EC_W-1:0];
    tp_sum   = $signed({2'b00, s4_tp_sc_r}) + 18'(temp_offset_r);
    tp_min18 = 18'(temp_min_r);
    tp_max18 = 18'(temp_max_r);
    // Upper clamp is tested first: with crossed limits a sum above the maximum gives the maximum, any other the minimum
    priority if (tp_sum > tp_max18) begin
      tp_clamp = temp_max_r;
    end else if (tp_sum < tp_min18) begin
      tp_clamp = temp_min_r;
    end else begin
      tp_clamp = tp_sum[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ec_r  <= ec_clamp;
      s5_tp_r  <= tp_clamp;
      s5_clr_r <= s4_clr_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: change test against the last values shown
  // ---------------------------------------------------------------------------
  logic signed [LEC_W-1:0]  last_ec_r, last_ec_base;
  logic signed [TEMP_W-1:0] last_tp_r, last_tp_base;
  logic signed [LEC_W:0]    ec_diff;
  logic signed [TEMP_W:0]   tp_diff;
  logic [LEC_W:0]           ec_mag;
  logic [TEMP_W:0]          tp_mag;
  logic                     ec_chg, tp_chg;
  logic [EC_W-1:0]          out_ec_r;
  logic signed [TEMP_W-1:0] out_tp_r;
  logic                     out_ec_chg_r, out_tp_chg_r;

  always_comb begin
    last_ec_base = s5_clr_r ? LAST_EC_RST : last_ec_r;
    last_tp_base = s5_clr_r ? LAST_TEMP_RST : last_tp_r;
    ec_diff      = $signed({2'b00, s5_ec_r}) - (LEC_W+1)'(last_ec_base);
    tp_diff      = (TEMP_W+1)'(s5_tp_r) - (TEMP_W+1)'(last_tp_base);
    ec_mag       = ec_diff[LEC_W] ? (LEC_W+1)'(-ec_diff) : ec_diff;
    tp_mag       = tp_diff[TEMP_W] ? (TEMP_W+1)'(-tp_diff) : tp_diff;
    ec_chg       = ec_mag > (LEC_W+1)'(ec_thr_r);
    tp_chg       = tp_mag > (TEMP_W+1)'(temp_thr_r);
  end

  // Advance the last values shown only when flagged; otherwise a restart returns them to -1.00
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ec_r <= LAST_EC_RST;
      last_tp_r <= LAST_TEMP_RST;
    end else if (adv && s5_vld_r) begin
      last_ec_r <= ec_chg ? $signed({1'b0, s5_ec_r}) : last_ec_base;
      last_tp_r <= tp_chg ? s5_tp_r : last_tp_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ec_r     <= s5_ec_r;
      out_tp_r     <= s5_tp_r;
      out_ec_chg_r <= ec_chg;
      out_tp_chg_r <= tp_chg;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(32 - EC_W - TEMP_W){1'b0}}, out_tp_r, out_ec_r};
  assign out_tuser  = {out_tp_chg_r, out_ec_chg_r};

endmodule
